// ===== rtl/gb3_pkg.sv =====
// Shared types, constants and register codes of the 3x3 Gaussian blur block.
package gb3_pkg;

    localparam int MAX_WIDTH_DEF   = 1024;
    localparam int COEF_BITS_DEF   = 16;
    localparam int MAX_HEIGHT      = 4096;
    localparam int ROW_W           = 13;
    localparam int PIX_W           = 24;
    localparam int CHAN_W          = 8;
    localparam int CFG_INDEX_W     = 3;
    localparam int CFG_DATA_W      = 16;
    localparam int IMG_WIDTH_RAW_W = 11;

    localparam int IMAGE_WIDTH_RST  = 1024;
    localparam int IMAGE_HEIGHT_RST = 768;
    localparam int COEF_CENTER_RST  = 9684;
    localparam int COEF_EDGE_RST    = 7754;
    localparam int COEF_CORNER_RST  = 6209;

    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_FLUSH = 1'b1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_IMAGE_WIDTH  = 3'd0,
        REG_IMAGE_HEIGHT = 3'd1,
        REG_COEF_CENTER  = 3'd2,
        REG_COEF_EDGE    = 3'd3,
        REG_COEF_CORNER  = 3'd4
    } gb3_cfg_reg_t;

    // Which neighbors of the center pixel lie inside the image.
    typedef struct packed {
        logic up;
        logic down;
        logic left;
        logic right;
    } gb3_tap_mask_t;

endpackage

// ===== rtl/gb3_line_store.sv =====
// Two line memories with read-modify-write and same-address forwarding.
module gb3_line_store #(
    parameter int MAX_WIDTH = gb3_pkg::MAX_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rd_en,
    input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
    input  logic                         wr_en,
    input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
    input  logic [gb3_pkg::PIX_W-1:0]    wr_pixel,
    output logic [gb3_pkg::PIX_W-1:0]    upper_q,
    output logic [gb3_pkg::PIX_W-1:0]    middle_q
);
    import gb3_pkg::*;

    logic [PIX_W-1:0] upper_mem  [MAX_WIDTH];
    logic [PIX_W-1:0] middle_mem [MAX_WIDTH];
    logic [PIX_W-1:0] upper_q_reg;
    logic [PIX_W-1:0] middle_q_reg;

    // Move the middle line up and store the new pixel in the middle line.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            upper_mem[wr_addr]  <= middle_q_reg;
            middle_mem[wr_addr] <= wr_pixel;
        end
    end

    // Bypass the array when the read hits the entry being written this cycle.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr_en && (wr_addr == rd_addr))
            begin
                upper_q_reg  <= middle_q_reg;
                middle_q_reg <= wr_pixel;
            end
            else
            begin
                upper_q_reg  <= upper_mem[rd_addr];
                middle_q_reg <= middle_mem[rd_addr];
            end
        end
    end

    assign upper_q  = upper_q_reg;
    assign middle_q = middle_q_reg;

endmodule

// ===== rtl/gb3_weigh.sv =====
// Weighted 3x3 sum of one color channel: masked group sums, products, scale and clip.
module gb3_weigh (
    input  logic                                clk,
    input  logic                                en,
    input  logic [8:0][gb3_pkg::CHAN_W-1:0]     taps,
    input  gb3_pkg::gb3_tap_mask_t              mask,
    input  logic [gb3_pkg::COEF_BITS_DEF-1:0]   coef_center,
    input  logic [gb3_pkg::COEF_BITS_DEF-1:0]   coef_edge,
    input  logic [gb3_pkg::COEF_BITS_DEF-1:0]   coef_corner,
    output logic [gb3_pkg::CHAN_W-1:0]          result
);
    import gb3_pkg::*;

    localparam int COEF_BITS = COEF_BITS_DEF;
    localparam int GRP_W     = CHAN_W + 2;
    localparam int ACC_W     = COEF_BITS + CHAN_W + 4;

    logic [CHAN_W-1:0]           center_reg;
    logic [GRP_W-1:0]            edge_sum_next;
    logic [GRP_W-1:0]            edge_sum_reg;
    logic [GRP_W-1:0]            corner_sum_next;
    logic [GRP_W-1:0]            corner_sum_reg;
    logic [COEF_BITS+CHAN_W-1:0] center_prod_reg;
    logic [COEF_BITS+GRP_W-1:0]  edge_prod_reg;
    logic [COEF_BITS+GRP_W-1:0]  corner_prod_reg;
    logic [ACC_W-1:0]            acc;
    logic [ACC_W-COEF_BITS-1:0]  scaled;
    logic [CHAN_W-1:0]           result_next;
    logic [CHAN_W-1:0]           result_reg;

    // Drop taps that fall outside the image.
    always_comb
    begin
        edge_sum_next = (mask.up    ? GRP_W'(taps[1]) : '0)
                      + (mask.left  ? GRP_W'(taps[3]) : '0)
                      + (mask.right ? GRP_W'(taps[5]) : '0)
                      + (mask.down  ? GRP_W'(taps[7]) : '0);
        corner_sum_next = ((mask.up   && mask.left)  ? GRP_W'(taps[0]) : '0)
                        + ((mask.up   && mask.right) ? GRP_W'(taps[2]) : '0)
                        + ((mask.down && mask.left)  ? GRP_W'(taps[6]) : '0)
                        + ((mask.down && mask.right) ? GRP_W'(taps[8]) : '0);
    end

    always_comb
    begin
        acc = ACC_W'(center_prod_reg) + ACC_W'(edge_prod_reg) + ACC_W'(corner_prod_reg);
        scaled = acc[ACC_W-1:COEF_BITS];
        result_next = (scaled > (ACC_W-COEF_BITS)'(255)) ? '1 : scaled[CHAN_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            center_reg      <= taps[4];
            edge_sum_reg    <= edge_sum_next;
            corner_sum_reg  <= corner_sum_next;
            center_prod_reg <= coef_center * center_reg;
            edge_prod_reg   <= coef_edge * edge_sum_reg;
            corner_prod_reg <= coef_corner * corner_sum_reg;
            result_reg      <= result_next;
        end
    end

    assign result = result_reg;

endmodule

// ===== rtl/gaussian_blur_3x3_rgb.sv =====
// Streaming 3x3 Gaussian blur of RGB pixels: top level.
//
// Pixels enter in raster order on the pix channel (pix_valid / pix_stall),
// one transfer per clock while pix_stall is low. action selects a pixel
// or a flush tick; flush ticks sent before the last pixel of a frame
// are consumed and ignored. Blurred pixels leave on the res channel
// (res_valid / res_stall); the last result of the frame carries frame_end.
// The result for a pixel is produced by the transfer that arrives one line
// plus one pixel after it; after the last pixel, image_width + 1 flush
// ticks drain the frame. From that transfer the result passes through the
// line memory read, window update, group sums, products and scaling.
// One item per clock unless the pipeline holds. The two line memories are
// read at the new column and written from stage 1 through separate ports.
// Registers are written over the cfg channel (cfg_valid / cfg_ready), which
// is always ready; write only while no frame is in flight.
// Reset clears the counters and the pipeline and loads the default
// geometry and weights; line memories are not cleared.
// While res_stall is high and the output register is full, the whole
// pipeline holds and pix_stall is raised.
module gaussian_blur_3x3_rgb #(
    parameter int MAX_WIDTH = gb3_pkg::MAX_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [gb3_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [gb3_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             pix_valid,
    output logic                             pix_stall,
    input  logic                             action,
    input  logic [gb3_pkg::CHAN_W-1:0]       red_in,
    input  logic [gb3_pkg::CHAN_W-1:0]       green_in,
    input  logic [gb3_pkg::CHAN_W-1:0]       blue_in,
    output logic                             res_valid,
    input  logic                             res_stall,
    output logic [gb3_pkg::CHAN_W-1:0]       red_out,
    output logic [gb3_pkg::CHAN_W-1:0]       green_out,
    output logic [gb3_pkg::CHAN_W-1:0]       blue_out,
    output logic                             frame_end
);
    import gb3_pkg::*;

    localparam int COEF_BITS = COEF_BITS_DEF;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int WCNT_W    = $clog2(MAX_WIDTH + 1);
    localparam int WIDE_W    = (WCNT_W > IMG_WIDTH_RAW_W) ? WCNT_W : IMG_WIDTH_RAW_W;
    localparam int WIDTH_RST = (IMAGE_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : IMAGE_WIDTH_RST;

    // Configuration
    logic [WCNT_W-1:0]    eff_width_reg;
    logic [ROW_W-1:0]     eff_height_reg;
    logic [COEF_BITS-1:0] coef_center_reg;
    logic [COEF_BITS-1:0] coef_edge_reg;
    logic [COEF_BITS-1:0] coef_corner_reg;
    logic [WIDE_W-1:0]    width_raw;
    logic [ROW_W-1:0]     height_raw;

    // Position and stage 0 decode
    logic [COL_W-1:0]  col_reg;
    logic [COL_W-1:0]  col_next;
    logic [ROW_W-1:0]  row_reg;
    logic [ROW_W-1:0]  row_next;
    logic              en;
    logic              take;
    logic              work;
    logic              drain;
    logic [WCNT_W-1:0] col_inc;
    logic              row_end;
    logic              emit;
    logic [ROW_W-1:0]  cr;
    logic [ROW_W-1:0]  cr_inc;
    logic [WCNT_W-1:0] cc;
    logic [WCNT_W-1:0] cc_inc;
    gb3_tap_mask_t     mask;
    logic              last;
    logic [PIX_W-1:0]  pixel;

    // Pipeline
    logic              s1_valid_reg;
    logic [PIX_W-1:0]  s1_data_reg;
    logic [COL_W-1:0]  s1_col_reg;
    logic              s1_emit_reg;
    gb3_tap_mask_t     s1_mask_reg;
    logic              s1_last_reg;
    logic              s2_valid_reg;
    gb3_tap_mask_t     s2_mask_reg;
    logic              s2_last_reg;
    logic              s3_valid_reg;
    logic              s3_last_reg;
    logic              s4_valid_reg;
    logic              s4_last_reg;
    logic              out_valid_reg;
    logic              out_last_reg;

    logic [PIX_W-1:0]  upper_q;
    logic [PIX_W-1:0]  middle_q;
    logic [PIX_W-1:0]  window_reg  [3][3];
    logic [PIX_W-1:0]  window_next [3][3];
    logic [8:0][CHAN_W-1:0] ch_taps   [3];
    logic [2:0][CHAN_W-1:0] ch_result;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        width_raw  = WIDE_W'(cfg_data[IMG_WIDTH_RAW_W-1:0]);
        height_raw = cfg_data[ROW_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eff_width_reg   <= WCNT_W'(WIDTH_RST);
            eff_height_reg  <= ROW_W'(IMAGE_HEIGHT_RST);
            coef_center_reg <= COEF_BITS'(COEF_CENTER_RST);
            coef_edge_reg   <= COEF_BITS'(COEF_EDGE_RST);
            coef_corner_reg <= COEF_BITS'(COEF_CORNER_RST);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (gb3_cfg_reg_t'(cfg_index))
                REG_IMAGE_WIDTH:
                begin
                    if (width_raw < WIDE_W'(2))
                        eff_width_reg <= WCNT_W'(2);
                    else if (width_raw > WIDE_W'(MAX_WIDTH))
                        eff_width_reg <= WCNT_W'(MAX_WIDTH);
                    else
                        eff_width_reg <= WCNT_W'(width_raw);
                end
                REG_IMAGE_HEIGHT:
                begin
                    if (height_raw < ROW_W'(2))
                        eff_height_reg <= ROW_W'(2);
                    else if (height_raw > ROW_W'(MAX_HEIGHT))
                        eff_height_reg <= ROW_W'(MAX_HEIGHT);
                    else
                        eff_height_reg <= height_raw;
                end
                REG_COEF_CENTER: coef_center_reg <= COEF_BITS'(cfg_data);
                REG_COEF_EDGE:   coef_edge_reg   <= COEF_BITS'(cfg_data);
                REG_COEF_CORNER: coef_corner_reg <= COEF_BITS'(cfg_data);
                default: ;
            endcase
        end
    end

    // Whole pipeline advances unless a finished result is held by the receiver.
    assign en        = !out_valid_reg || !res_stall;
    assign pix_stall = !en;
    assign take      = pix_valid && !pix_stall;

    always_comb
    begin
        drain   = row_reg >= eff_height_reg;
        work    = take && (drain || (action == ACT_PIXEL));
        pixel   = drain ? '0 : {red_in, green_in, blue_in};
        col_inc = WCNT_W'(col_reg) + WCNT_W'(1);
        row_end = col_inc >= eff_width_reg;

        // Center of the window lags the input by one row and one column.
        if (col_reg == '0)
        begin
            emit = row_reg >= ROW_W'(2);
            cr   = row_reg - ROW_W'(2);
            cc   = eff_width_reg - WCNT_W'(1);
        end
        else
        begin
            emit = row_reg >= ROW_W'(1);
            cr   = row_reg - ROW_W'(1);
            cc   = WCNT_W'(col_reg) - WCNT_W'(1);
        end
        cr_inc     = cr + ROW_W'(1);
        cc_inc     = cc + WCNT_W'(1);
        mask.up    = cr != '0;
        mask.down  = cr_inc < eff_height_reg;
        mask.left  = cc != '0;
        mask.right = cc_inc < eff_width_reg;
        last       = emit && !mask.down && !mask.right;

        col_next = col_reg;
        row_next = row_reg;
        if (work)
        begin
            if (last)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (row_end)
            begin
                col_next = '0;
                row_next = row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_inc[COL_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (en)
            begin
                s1_valid_reg  <= work;
                s2_valid_reg  <= s1_valid_reg && s1_emit_reg;
                s3_valid_reg  <= s2_valid_reg;
                s4_valid_reg  <= s3_valid_reg;
                out_valid_reg <= s4_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_data_reg  <= pixel;
            s1_col_reg   <= col_reg;
            s1_emit_reg  <= emit;
            s1_mask_reg  <= mask;
            s1_last_reg  <= last;
            s2_mask_reg  <= s1_mask_reg;
            s2_last_reg  <= s1_last_reg;
            s3_last_reg  <= s2_last_reg;
            s4_last_reg  <= s3_last_reg;
            out_last_reg <= s4_last_reg;
        end
    end

    gb3_line_store #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_store (
        .clk      (clk),
        .rd_en    (work),
        .rd_addr  (col_reg),
        .wr_en    (en && s1_valid_reg),
        .wr_addr  (s1_col_reg),
        .wr_pixel (s1_data_reg),
        .upper_q  (upper_q),
        .middle_q (middle_q)
    );

    // Shift the window left and bring in the new column.
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            window_next[r][0] = window_reg[r][1];
            window_next[r][1] = window_reg[r][2];
        end
        window_next[0][2] = upper_q;
        window_next[1][2] = middle_q;
        window_next[2][2] = s1_data_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en && s1_valid_reg)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    window_reg[r][c] <= window_next[r][c];
                end
            end
        end
    end

    // Channel 0 is red (top byte), 2 is blue.
    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    ch_taps[ch][r*3+c] = window_reg[r][c][(2-ch)*CHAN_W +: CHAN_W];
                end
            end
        end
    end

    for (genvar ch = 0; ch < 3; ch++)
    begin : g_chan
        gb3_weigh u_weigh (
            .clk         (clk),
            .en          (en),
            .taps        (ch_taps[ch]),
            .mask        (s2_mask_reg),
            .coef_center (coef_center_reg),
            .coef_edge   (coef_edge_reg),
            .coef_corner (coef_corner_reg),
            .result      (ch_result[ch])
        );
    end

    assign res_valid = out_valid_reg;
    assign red_out   = ch_result[0];
    assign green_out = ch_result[1];
    assign blue_out  = ch_result[2];
    assign frame_end = out_last_reg;

endmodule
